// ===== hw/rtl/bm3_pkg.sv =====
package bm3_pkg;

  // Frame geometry limits.
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  // Column and row counters cover the largest frame.
  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);

  // Configuration port.
  localparam int DIM_W      = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;

  localparam logic [DIM_W-1:0] WIDTH_RST  = 11'd640;
  localparam logic [DIM_W-1:0] HEIGHT_RST = 11'd480;

  // Mode register codes.
  localparam logic MODE_ERODE  = 1'b0;
  localparam logic MODE_DILATE = 1'b1;

  // Input operation codes.
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  // Result pixel values.
  localparam logic [7:0] PIX_ON  = 8'd255;
  localparam logic [7:0] PIX_OFF = 8'd0;

  // Line store: one entry per column, one bit per row parity.
  localparam int LS_WIDTH = 2;

  // Result queue.
  localparam int OQ_DEPTH = 4;
  localparam int OQ_AW    = $clog2(OQ_DEPTH);
  localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

  typedef enum logic {
    PHASE_PIXELS,
    PHASE_DRAIN
  } phase_e;

  typedef struct packed {
    logic       operation;
    logic [7:0] pixel;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_pixel;
    logic       end_of_frame;
    logic       last_of_run;
  } out_item_t;

  // Column work handed from the address stage to the window stage.
  typedef struct packed {
    logic             valid;
    logic             produce;
    logic             wr_en;
    logic             wr_par;
    logic             pix_bit;
    logic             mid_par;
    logic             top_eq;
    logic             first;
    logic             row_end;
    logic             last_row;
    logic             fwd;
    logic [COL_W-1:0] addr;
  } col_work_t;

  // Window decision for one left, centre and right column triple.
  function automatic logic [7:0] window_value(logic mode, logic [2:0] l, logic [2:0] c,
                                              logic [2:0] r);
    logic [8:0] win;
    win = {r, c, l};
    if (mode == MODE_DILATE) begin
      window_value = (|win) ? PIX_ON : PIX_OFF;
    end else begin
      window_value = (&win) ? PIX_ON : PIX_OFF;
    end
  endfunction

endpackage

// ===== hw/rtl/bm3_if.sv =====
// Input stream channel.
interface bm3_in_if import bm3_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// Result stream channel.
interface bm3_out_if import bm3_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// ===== hw/rtl/bm3_ram.sv =====
// Simple dual-port RAM with a registered read port.
module bm3_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port returns the old contents on a same-address write.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/binary_morphology_3x3_core.sv =====
// 3x3 binary erosion or dilation of a raster frame with replicated borders.
// Pixels arrive one per transfer in raster order; only zero versus nonzero is
// kept. Results for row r-1 leave while row r arrives, two at the end of a row,
// and after the last row W flush items drain the final result row. The block
// takes one item per clock: each item reads its column entry of a 1024 x 2-bit
// line store RAM and writes it back from the window stage, a single read and
// write port pair that sets the rate; a result passes the window stage and the
// result queue. Input is held off only while more than two results wait in
// the four entry result queue. The line store needs no clearing pass after
// reset. Writing frame_width or frame_height restarts the frame.
module binary_morphology_3x3_core import bm3_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  bm3_in_if.sink                in_i,
  bm3_out_if.source             out_o
);

  // Configuration registers.
  logic             mode_q;
  logic [DIM_W-1:0] width_q;
  logic [DIM_W-1:0] height_q;
  logic             restart;

  // Frame position.
  phase_e           phase_q, phase_d;
  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic [COL_W-1:0] drain_q, drain_d;

  // Effective geometry minus one.
  logic [COL_W-1:0] wm1;
  logic [ROW_W-1:0] hm1;

  // Address stage.
  logic             in_accept;
  logic             act_pix;
  logic             act_flush;
  logic [COL_W-1:0] cur_col;
  logic             cur_row_end;
  logic             fwd_hit;

  // Window stage.
  col_work_t           s1_q, s1_d;
  logic                s1_fire;
  logic [LS_WIDTH-1:0] ram_rdata;
  logic [LS_WIDTH-1:0] rd_entry;
  logic [LS_WIDTH-1:0] wr_entry;
  logic [LS_WIDTH-1:0] fwd_q;
  logic                ram_we;
  logic                mid_bit;
  logic                top_bit;
  logic                low_bit;
  logic [2:0]          triple;
  logic [5:0]          window_q, window_d;
  logic [1:0]          res_cnt;
  out_item_t           res_a;
  out_item_t           res_b;

  // Result queue.
  out_item_t        oq_q [OQ_DEPTH];
  logic [OQ_AW-1:0] oq_wp_q;
  logic [OQ_AW-1:0] oq_rp_q;
  logic [OQ_CW-1:0] oq_cnt_q;
  logic             out_pop;

  // Configuration writes; a geometry write restarts the frame.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_ERODE;
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MODE:   mode_q   <= cfg_data_i[0];
        CFG_WIDTH:  width_q  <= cfg_data_i[DIM_W-1:0];
        CFG_HEIGHT: height_q <= cfg_data_i[DIM_W-1:0];
        default:    ;
      endcase
    end
  end

  assign restart = cfg_we_i && (cfg_idx_i == CFG_WIDTH || cfg_idx_i == CFG_HEIGHT);

  // Clamp the geometry to the supported range.
  always_comb begin
    if (width_q == '0) begin
      wm1 = '0;
    end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
      wm1 = COL_W'(MAX_WIDTH - 1);
    end else begin
      wm1 = COL_W'(width_q - 1'b1);
    end
    if (height_q == '0) begin
      hm1 = '0;
    end else if (32'(height_q) > 32'(MAX_HEIGHT)) begin
      hm1 = ROW_W'(MAX_HEIGHT - 1);
    end else begin
      hm1 = ROW_W'(height_q - 1'b1);
    end
  end

  // Input transfer and decode of the item.
  assign s1_fire   = s1_q.valid && (oq_cnt_q <= OQ_CW'(OQ_DEPTH - 2));
  assign in_i.ready = !s1_q.valid || s1_fire;
  assign in_accept = in_i.valid && in_i.ready;

  assign act_pix     = (in_i.data.operation == OP_PIXEL) && (phase_q == PHASE_PIXELS);
  assign act_flush   = (in_i.data.operation == OP_FLUSH) && (phase_q == PHASE_DRAIN);
  assign cur_col     = act_flush ? drain_q : col_q;
  assign cur_row_end = (cur_col == wm1);

  // Next frame position.
  always_comb begin
    phase_d = phase_q;
    col_d   = col_q;
    row_d   = row_q;
    drain_d = drain_q;
    if (restart) begin
      phase_d = PHASE_PIXELS;
      col_d   = '0;
      row_d   = '0;
      drain_d = '0;
    end else if (in_accept && act_pix) begin
      if (cur_row_end) begin
        col_d = '0;
        if (row_q == hm1) begin
          row_d   = '0;
          phase_d = PHASE_DRAIN;
          drain_d = '0;
        end else begin
          row_d = row_q + 1'b1;
        end
      end else begin
        col_d = col_q + 1'b1;
      end
    end else if (in_accept && act_flush) begin
      if (cur_row_end) begin
        phase_d = PHASE_PIXELS;
        drain_d = '0;
      end else begin
        drain_d = drain_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PHASE_PIXELS;
      col_q   <= '0;
      row_q   <= '0;
      drain_q <= '0;
    end else begin
      phase_q <= phase_d;
      col_q   <= col_d;
      row_q   <= row_d;
      drain_q <= drain_d;
    end
  end

  // A read of the entry being written this cycle takes the written data.
  assign fwd_hit = s1_fire && s1_q.wr_en && (s1_q.addr == cur_col);

  // Load the window stage.
  always_comb begin
    s1_d = s1_q;
    if (in_accept && (act_pix || act_flush)) begin
      s1_d.valid    = 1'b1;
      s1_d.produce  = act_flush || (row_q != '0);
      s1_d.wr_en    = act_pix;
      s1_d.wr_par   = row_q[0];
      s1_d.pix_bit  = |in_i.data.pixel;
      s1_d.mid_par  = act_flush ? hm1[0] : ~row_q[0];
      s1_d.top_eq   = act_flush ? (hm1 == '0) : (row_q == ROW_W'(1));
      s1_d.first    = (cur_col == '0);
      s1_d.row_end  = cur_row_end;
      s1_d.last_row = act_flush;
      s1_d.fwd      = fwd_hit;
      s1_d.addr     = cur_col;
    end else if (s1_fire) begin
      s1_d.valid = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '0;
    end else begin
      s1_q <= s1_d;
    end
  end

  // Forwarded entry data.
  always_ff @(posedge clk_i) begin
    if (in_accept && fwd_hit) begin
      fwd_q <= wr_entry;
    end
  end

  // Line store: both row parities of a column share one entry.
  bm3_ram #(
    .WIDTH (LS_WIDTH),
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (s1_q.addr),
    .wdata_i (wr_entry),
    .re_i    (in_accept),
    .raddr_i (cur_col),
    .rdata_o (ram_rdata)
  );

  // Column triple from the stored rows and the arriving pixel.
  always_comb begin
    rd_entry = s1_q.fwd ? fwd_q : ram_rdata;
    mid_bit  = rd_entry[s1_q.mid_par];
    top_bit  = s1_q.top_eq ? mid_bit : rd_entry[~s1_q.mid_par];
    low_bit  = s1_q.last_row ? mid_bit : s1_q.pix_bit;
    triple   = {low_bit, mid_bit, top_bit};
    wr_entry = rd_entry;
    wr_entry[s1_q.wr_par] = s1_q.pix_bit;
  end

  assign ram_we = s1_fire && s1_q.wr_en;

  // Results of this column and the window shift.
  always_comb begin
    res_cnt  = 2'd0;
    res_a    = '0;
    res_b    = '0;
    window_d = window_q;
    if (s1_q.produce) begin
      if (s1_q.first) begin
        window_d = {triple, triple};
        if (s1_q.row_end) begin
          res_cnt            = 2'd1;
          res_a.out_pixel    = window_value(mode_q, triple, triple, triple);
          res_a.end_of_frame = s1_q.last_row;
          res_a.last_of_run  = 1'b1;
        end
      end else begin
        window_d          = {triple, window_q[5:3]};
        res_a.out_pixel   = window_value(mode_q, window_q[2:0], window_q[5:3], triple);
        res_a.last_of_run = !s1_q.row_end;
        res_cnt           = 2'd1;
        if (s1_q.row_end) begin
          res_cnt            = 2'd2;
          res_b.out_pixel    = window_value(mode_q, window_q[5:3], triple, triple);
          res_b.end_of_frame = s1_q.last_row;
          res_b.last_of_run  = 1'b1;
        end
      end
      if (s1_q.row_end && s1_q.last_row) begin
        window_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= '0;
    end else if (restart) begin
      window_q <= '0;
    end else if (s1_fire) begin
      window_q <= window_d;
    end
  end

  // Result queue storage.
  always_ff @(posedge clk_i) begin
    if (s1_fire && res_cnt != 2'd0) begin
      oq_q[oq_wp_q] <= res_a;
    end
    if (s1_fire && res_cnt == 2'd2) begin
      oq_q[oq_wp_q + 1'b1] <= res_b;
    end
  end

  // Result queue pointers.
  assign out_pop = out_o.valid && out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oq_wp_q  <= '0;
      oq_rp_q  <= '0;
      oq_cnt_q <= '0;
    end else begin
      if (s1_fire) begin
        oq_wp_q <= oq_wp_q + OQ_AW'(res_cnt);
      end
      if (out_pop) begin
        oq_rp_q <= oq_rp_q + 1'b1;
      end
      oq_cnt_q <= oq_cnt_q + (s1_fire ? OQ_CW'(res_cnt) : OQ_CW'(0)) - OQ_CW'(out_pop);
    end
  end

  assign out_o.valid = (oq_cnt_q != '0);
  assign out_o.data  = oq_q[oq_rp_q];

  // The result queue never holds more than its depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    oq_cnt_q <= OQ_CW'(OQ_DEPTH))
    else $error("result queue overflow");

  // A read that meets a write to the same entry is served by forwarding.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && in_accept && (act_pix || act_flush) && s1_q.addr == cur_col)
    |=> s1_q.fwd)
    else $error("line store hazard not forwarded");

  // The last result of the frame also closes its run.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.data.end_of_frame) |-> out_o.data.last_of_run)
    else $error("end of frame without end of run");

  // A pixel during the drain does no work.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && phase_q == PHASE_DRAIN && in_i.data.operation == OP_PIXEL)
    |=> !s1_q.valid)
    else $error("pixel item taken during drain");

endmodule
